@@ hdl/base64_line_frame_receiver_unit_defines.svh @@
// Assertion macros for the base64 line frame receiver.
// Included by base64_line_frame_receiver_unit.sv; no other dependencies.
`ifndef BASE64_LINE_FRAME_RECEIVER_UNIT_DEFINES_SVH
`define BASE64_LINE_FRAME_RECEIVER_UNIT_DEFINES_SVH

// Condition implies consequence in the same cycle.
`define B64LFR_ASSERT_IMPL(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("b64lfr: same-cycle check failed");

// Condition implies consequence in the next cycle.
`define B64LFR_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("b64lfr: next-cycle check failed");

`endif

@@ hdl/b64lfr_pkg.sv @@
// Constants, codes and the base64 character decoder for the line frame receiver.
// No dependencies.
package b64lfr_pkg;

   localparam int ROWS       = 25;
   localparam int COLS       = 80;
   localparam int LINE_CHARS = 108;
   localparam int PEND_LEN   = COLS + 1;

   localparam int CNT_W   = $clog2(LINE_CHARS + 2);
   localparam int ROW_W   = $clog2(ROWS + 1);
   localparam int CHAR_AW = $clog2((ROWS + 1) * COLS);
   localparam int PEND_AW = $clog2(PEND_LEN);
   localparam int CP_W    = $clog2(COLS + 1);
   localparam int BASE_W  = $clog2((LINE_CHARS / 4) * 3 + 3);

   localparam logic [CNT_W-1:0] LINE_LEN_C = CNT_W'(LINE_CHARS);
   localparam logic [CNT_W-1:0] LINE_SAT_C = CNT_W'(LINE_CHARS + 1);
   localparam logic [ROW_W-1:0] ROWS_C     = ROW_W'(ROWS);
   localparam logic [CP_W-1:0]  COLS_C     = CP_W'(COLS);

   localparam logic [1:0] FUNC_SERIAL    = 2'd0;
   localparam logic [1:0] FUNC_READ_CHAR = 2'd1;
   localparam logic [1:0] FUNC_READ_FLAG = 2'd2;

   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;

   // {invalid, sextet}
   function automatic logic [6:0] sextet_of(input logic [7:0] c);
      logic [6:0] r;
      r = {1'b1, 6'd0};
      if (c inside {[8'h41:8'h5A]}) begin
         r = {1'b0, 6'(c - 8'h41)};
      end else if (c inside {[8'h61:8'h7A]}) begin
         r = {1'b0, 6'(c - 8'h61 + 8'd26)};
      end else if (c inside {[8'h30:8'h39]}) begin
         r = {1'b0, 6'(c - 8'h30 + 8'd52)};
      end else if (c == CHAR_PLUS) begin
         r = {1'b0, 6'd62};
      end else if (c == CHAR_SLASH) begin
         r = {1'b0, 6'd63};
      end
      return r;
   endfunction

endpackage

@@ hdl/base64_line_frame_receiver_unit.sv @@
// Base64 line frame receiver: line decode, pending line, character and flags stores.
// Depends on b64lfr_pkg and base64_line_frame_receiver_unit_defines.svh.
//
// One beat in, one beat out. A read beat or a plain serial byte goes through
// accept, then the registered memory read and result load. A byte that
// completes a group of four base64 characters writes the three decoded bytes
// into the pending-line memory through its single write port, one per cycle.
// A line end that commits a line copies the pending line into the store
// memory one byte a cycle through the pending memory's read port. The store
// memory holds the character rows followed by the flags line as one more row.
// The result register lets the next beat be accepted while a result waits.
// After reset every row of the character store reads as spaces and the flags
// store as zero until written; there is no clearing pass.
`include "base64_line_frame_receiver_unit_defines.svh"

module base64_line_frame_receiver_unit
   import b64lfr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_func,
   input  logic [7:0] req_rx_byte,
   input  logic [4:0] req_read_row,
   input  logic [6:0] req_read_col,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_read_data,
   output logic       rsp_line_accepted,
   output logic       rsp_line_dropped,
   output logic       rsp_frame_done,
   output logic       rsp_graphic_mode
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_QUAD   = 4'b0010,
      ST_COPY   = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   typedef enum logic [1:0] {
      RD_NONE,
      RD_CHAR,
      RD_FLAG
   } rd_sel_type;

   logic [7:0] char_mem [(ROWS+1)*COLS];
   logic [7:0] pend_mem [PEND_LEN];

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [17:0]       accum_ff, accum_in;
   logic              bad_ff, bad_in;
   logic [ROW_W-1:0]  expected_ff, expected_in;
   logic [ROWS:0]     row_valid_ff, row_valid_in;
   logic              graphic_ff, graphic_in;
   logic [CP_W-1:0]   copy_cnt_ff, copy_cnt_in;
   logic [ROW_W-1:0]  copy_row_ff, copy_row_in;
   logic              copy_flags_ff, copy_flags_in;
   logic              quad_step_ff, quad_step_in;
   logic [15:0]       quad_ff, quad_in;
   logic [BASE_W-1:0] base_ff, base_in;
   logic [7:0]        line_num_ff, line_num_in;
   logic              res_acc_ff, res_acc_in;
   logic              res_drop_ff, res_drop_in;
   logic              res_done_ff, res_done_in;
   rd_sel_type        rd_sel_ff, rd_sel_in;
   logic              rd_range_ff, rd_range_in;
   logic              rd_ok_ff, rd_ok_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_data_ff, rsp_data_in;
   logic              rsp_acc_ff, rsp_acc_in;
   logic              rsp_drop_ff, rsp_drop_in;
   logic              rsp_done_ff, rsp_done_in;
   logic              rsp_graphic_ff, rsp_graphic_in;

   logic               pend_we, pend_rd_en;
   logic [PEND_AW-1:0] pend_wr_addr, pend_rd_addr;
   logic [7:0]         pend_wr_data, pend_q;
   logic               char_we, char_rd_en;
   logic [CHAR_AW-1:0] char_wr_addr, char_rd_addr;
   logic [7:0]         char_q;

   logic [6:0]        sext;
   logic [23:0]       full;
   logic [BASE_W-1:0] quad_idx, quad_base, next_idx;
   logic              line_ok, in_seq, out_free, row_in_range, col_in_range;
   logic [7:0]        rd_value;

   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign sext         = sextet_of(req_rx_byte);
   assign full         = {accum_ff, sext[5:0]};
   assign quad_idx     = BASE_W'(count_ff >> 2);
   assign quad_base    = (quad_idx << 1) + quad_idx;
   assign next_idx     = base_ff + (quad_step_ff ? BASE_W'(2) : BASE_W'(1));
   assign line_ok      = (count_ff == LINE_LEN_C) && !bad_ff;
   assign in_seq       = line_num_ff == 8'(expected_ff);
   assign row_in_range = 32'(req_read_row) < ROWS;
   assign col_in_range = 32'(req_read_col) < COLS;

   always_comb begin
      rd_value = 8'h00;
      case (rd_sel_ff)
         RD_CHAR: begin
            if (rd_ok_ff) begin
               rd_value = char_q;
            end else if (rd_range_ff) begin
               rd_value = CHAR_SPACE;
            end
         end
         RD_FLAG: begin
            if (rd_ok_ff) begin
               rd_value = char_q;
            end
         end
         default: rd_value = 8'h00;
      endcase
   end

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      accum_in       = accum_ff;
      bad_in         = bad_ff;
      expected_in    = expected_ff;
      row_valid_in   = row_valid_ff;
      graphic_in     = graphic_ff;
      copy_cnt_in    = copy_cnt_ff;
      copy_row_in    = copy_row_ff;
      copy_flags_in  = copy_flags_ff;
      quad_step_in   = quad_step_ff;
      quad_in        = quad_ff;
      base_in        = base_ff;
      line_num_in    = line_num_ff;
      res_acc_in     = res_acc_ff;
      res_drop_in    = res_drop_ff;
      res_done_in    = res_done_ff;
      rd_sel_in      = rd_sel_ff;
      rd_range_in    = rd_range_ff;
      rd_ok_in       = rd_ok_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_data_in    = rsp_data_ff;
      rsp_acc_in     = rsp_acc_ff;
      rsp_drop_in    = rsp_drop_ff;
      rsp_done_in    = rsp_done_ff;
      rsp_graphic_in = rsp_graphic_ff;
      pend_we        = 1'b0;
      pend_wr_addr   = '0;
      pend_wr_data   = 8'h00;
      pend_rd_en     = 1'b0;
      pend_rd_addr   = '0;
      char_we        = 1'b0;
      char_wr_addr   = '0;
      char_rd_en     = 1'b0;
      char_rd_addr   = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in    = ST_FINISH;
               res_acc_in  = 1'b0;
               res_drop_in = 1'b0;
               res_done_in = 1'b0;
               rd_sel_in   = RD_NONE;
               rd_range_in = 1'b0;
               rd_ok_in    = 1'b0;
               case (req_func)
                  FUNC_SERIAL: begin
                     if (req_rx_byte == CHAR_LF || req_rx_byte == CHAR_CR) begin
                        if (count_ff != '0) begin
                           if (line_ok && in_seq) begin
                              res_acc_in    = 1'b1;
                              res_done_in   = expected_ff == ROWS_C;
                              copy_row_in   = expected_ff;
                              copy_flags_in = expected_ff == ROWS_C;
                              copy_cnt_in   = '0;
                              expected_in   = (expected_ff == ROWS_C) ? '0
                                              : expected_ff + 1'b1;
                              state_in      = ST_COPY;
                           end else begin
                              res_drop_in = 1'b1;
                              if (line_ok) begin
                                 expected_in = '0;
                              end
                           end
                        end
                        count_in = '0;
                        accum_in = '0;
                        bad_in   = 1'b0;
                     end else begin
                        if (count_ff < LINE_LEN_C) begin
                           bad_in = bad_ff | sext[6];
                           if (count_ff[1:0] == 2'b11) begin
                              accum_in     = '0;
                              quad_in      = full[15:0];
                              base_in      = quad_base;
                              quad_step_in = 1'b0;
                              pend_we      = 32'(quad_base) < PEND_LEN;
                              pend_wr_addr = PEND_AW'(quad_base);
                              pend_wr_data = full[23:16];
                              if (quad_base == '0) begin
                                 line_num_in = full[23:16];
                              end
                              state_in = ST_QUAD;
                           end else begin
                              accum_in = {accum_ff[11:0], sext[5:0]};
                           end
                        end
                        if (count_ff < LINE_SAT_C) begin
                           count_in = count_ff + 1'b1;
                        end
                     end
                  end
                  FUNC_READ_CHAR: begin
                     rd_sel_in    = RD_CHAR;
                     rd_range_in  = row_in_range && col_in_range;
                     rd_ok_in     = row_in_range && col_in_range
                                    && row_valid_ff[ROW_W'(req_read_row)];
                     char_rd_en   = row_in_range && col_in_range;
                     char_rd_addr = CHAR_AW'(req_read_row) * CHAR_AW'(COLS)
                                    + CHAR_AW'(req_read_col);
                  end
                  FUNC_READ_FLAG: begin
                     rd_sel_in    = RD_FLAG;
                     rd_range_in  = col_in_range;
                     rd_ok_in     = col_in_range && row_valid_ff[ROWS];
                     char_rd_en   = col_in_range;
                     char_rd_addr = CHAR_AW'(ROWS * COLS) + CHAR_AW'(req_read_col);
                  end
                  default: rd_sel_in = RD_NONE;
               endcase
            end
         end
         ST_QUAD: begin
            pend_we      = 32'(next_idx) < PEND_LEN;
            pend_wr_addr = PEND_AW'(next_idx);
            pend_wr_data = quad_step_ff ? quad_ff[7:0] : quad_ff[15:8];
            quad_step_in = !quad_step_ff;
            if (quad_step_ff) begin
               state_in = ST_FINISH;
            end
         end
         ST_COPY: begin
            pend_rd_en   = copy_cnt_ff < COLS_C;
            pend_rd_addr = PEND_AW'(copy_cnt_ff + 1'b1);
            char_wr_addr = CHAR_AW'(copy_row_ff) * CHAR_AW'(COLS)
                           + CHAR_AW'(copy_cnt_ff - 1'b1);
            char_we      = copy_cnt_ff != '0;
            if (copy_flags_ff && copy_cnt_ff == CP_W'(1)) begin
               graphic_in = pend_q != 8'h00;
            end
            copy_cnt_in = copy_cnt_ff + 1'b1;
            if (copy_cnt_ff == COLS_C) begin
               row_valid_in[copy_row_ff] = 1'b1;
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_data_in    = rd_value;
               rsp_acc_in     = res_acc_ff;
               rsp_drop_in    = res_drop_ff;
               rsp_done_in    = res_done_ff;
               rsp_graphic_in = graphic_ff;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (pend_we) begin
         pend_mem[pend_wr_addr] <= pend_wr_data;
      end
      if (pend_rd_en) begin
         pend_q <= pend_mem[pend_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (char_we) begin
         char_mem[char_wr_addr] <= pend_q;
      end
      if (char_rd_en) begin
         char_q <= char_mem[char_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         accum_ff      <= '0;
         bad_ff        <= 1'b0;
         expected_ff   <= '0;
         row_valid_ff  <= '0;
         graphic_ff    <= 1'b0;
         copy_cnt_ff   <= '0;
         quad_step_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         accum_ff      <= accum_in;
         bad_ff        <= bad_in;
         expected_ff   <= expected_in;
         row_valid_ff  <= row_valid_in;
         graphic_ff    <= graphic_in;
         copy_cnt_ff   <= copy_cnt_in;
         quad_step_ff  <= quad_step_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      copy_row_ff    <= copy_row_in;
      copy_flags_ff  <= copy_flags_in;
      quad_ff        <= quad_in;
      base_ff        <= base_in;
      line_num_ff    <= line_num_in;
      res_acc_ff     <= res_acc_in;
      res_drop_ff    <= res_drop_in;
      res_done_ff    <= res_done_in;
      rd_sel_ff      <= rd_sel_in;
      rd_range_ff    <= rd_range_in;
      rd_ok_ff       <= rd_ok_in;
      rsp_data_ff    <= rsp_data_in;
      rsp_acc_ff     <= rsp_acc_in;
      rsp_drop_ff    <= rsp_drop_in;
      rsp_done_ff    <= rsp_done_in;
      rsp_graphic_ff <= rsp_graphic_in;
   end

   assign req_stall         = state_ff != ST_IDLE;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_read_data     = rsp_data_ff;
   assign rsp_line_accepted = rsp_acc_ff;
   assign rsp_line_dropped  = rsp_drop_ff;
   assign rsp_frame_done    = rsp_done_ff;
   assign rsp_graphic_mode  = rsp_graphic_ff;

   `B64LFR_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)
   `B64LFR_ASSERT_IMPL(a_done_needs_accept, clock, reset, rsp_valid && rsp_frame_done, rsp_line_accepted && !rsp_line_dropped)
   `B64LFR_ASSERT_IMPL(a_expected_bound, clock, reset, state_ff != ST_COPY, expected_ff <= ROWS_C)
   `B64LFR_ASSERT_IMPL(a_copy_bound, clock, reset, state_ff == ST_COPY, copy_cnt_ff <= COLS_C)

endmodule

@@ tb/base64_line_frame_receiver_unit_tb.sv @@
`timescale 1ns / 100ps
// Testbench for base64_line_frame_receiver_unit: directed and random serial and read beats,
// each result checked against a behavioral mirror of the line decoder and both stores.
// Depends on b64lfr_pkg and the receiver RTL.
module base64_line_frame_receiver_unit_tb;
   import b64lfr_pkg::*;

   localparam logic [1:0] FUNC_NOP = 2'd3;

   typedef struct {
      logic [1:0] func;
      logic [7:0] rx;
      logic [4:0] row;
      logic [6:0] col;
      bit         hold;
   } req_beat_type;

   typedef struct {
      logic [7:0] read_data;
      logic       accepted;
      logic       dropped;
      logic       done;
      logic       graphic;
   } rsp_beat_type;

   typedef enum int {
      LINE_GOOD,
      LINE_OUT_OF_SEQ,
      LINE_SHORT,
      LINE_LONG,
      LINE_BAD_CHAR,
      LINE_NOISE
   } line_kind_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [1:0] req_func = FUNC_SERIAL;
   logic [7:0] req_rx_byte = '0;
   logic [4:0] req_read_row = '0;
   logic [6:0] req_read_col = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_read_data;
   logic       rsp_line_accepted;
   logic       rsp_line_dropped;
   logic       rsp_frame_done;
   logic       rsp_graphic_mode;

   base64_line_frame_receiver_unit dut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // mirror of the receiver state
   int unsigned line_chars_seen;
   logic [17:0] quad_bits;
   bit          line_has_bad;
   logic [7:0]  pend_mirror [PEND_LEN];
   int          next_line_no;
   logic [7:0]  char_mirror [ROWS][COLS];
   logic [7:0]  flag_mirror [COLS];

   req_beat_type queued_beats [$];
   rsp_beat_type predicted_rsp [$];
   int unsigned  beats_sent, beats_in, rsps_out, rsps_seen;
   int unsigned  gap_left, stall_left, cycles, fail_count;
   int unsigned  cycle_limit = 1000000;
   bit           req_calm, rsp_calm, hold_next;
   int           gen_line, gen_frames;

   function automatic bit sextet_value(input logic [7:0] c, output logic [5:0] v);
      v = 6'd0;
      if (c >= "A" && c <= "Z") begin
         v = 6'(c - "A");
      end else if (c >= "a" && c <= "z") begin
         v = 6'(c - "a" + 26);
      end else if (c >= "0" && c <= "9") begin
         v = 6'(c - "0" + 52);
      end else if (c == CHAR_PLUS) begin
         v = 6'd62;
      end else if (c == CHAR_SLASH) begin
         v = 6'd63;
      end else begin
         return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic logic [7:0] sextet_char(input logic [5:0] s);
      if (s < 26) return 8'("A" + s);
      if (s < 52) return 8'("a" + s - 26);
      if (s < 62) return 8'("0" + s - 52);
      return (s == 6'd62) ? CHAR_PLUS : CHAR_SLASH;
   endfunction

   function automatic rsp_beat_type receive_beat(input logic [1:0] func, input logic [7:0] rx,
                                                 input logic [4:0] row, input logic [6:0] col);
      rsp_beat_type r;
      logic [5:0]   s;
      logic [23:0]  full;
      int unsigned  base;
      r.read_data = '0;
      r.accepted  = 1'b0;
      r.dropped   = 1'b0;
      r.done      = 1'b0;
      case (func)
         FUNC_SERIAL: begin
            if (rx == CHAR_LF || rx == CHAR_CR) begin
               if (line_chars_seen != 0) begin
                  if (line_chars_seen == LINE_CHARS && !line_has_bad) begin
                     if (int'(pend_mirror[0]) == next_line_no) begin
                        for (int i = 0; i < COLS; i++) begin
                           if (next_line_no < ROWS) char_mirror[next_line_no][i] = pend_mirror[i+1];
                           else flag_mirror[i] = pend_mirror[i+1];
                        end
                        r.accepted = 1'b1;
                        next_line_no++;
                        if (next_line_no > ROWS) begin
                           r.done = 1'b1;
                           next_line_no = 0;
                        end
                     end else begin
                        next_line_no = 0;
                        r.dropped = 1'b1;
                     end
                  end else begin
                     r.dropped = 1'b1;
                  end
               end
               line_chars_seen = 0;
               quad_bits = '0;
               line_has_bad = 1'b0;
            end else begin
               if (line_chars_seen < LINE_CHARS) begin
                  if (!sextet_value(rx, s)) begin
                     line_has_bad = 1'b1;
                     s = 6'd0;
                  end
                  if (line_chars_seen % 4 == 3) begin
                     full = {quad_bits, s};
                     base = (line_chars_seen / 4) * 3;
                     for (int k = 0; k < 3; k++) begin
                        if (base + k < PEND_LEN) pend_mirror[base+k] = full[23-8*k -: 8];
                     end
                     quad_bits = '0;
                  end else begin
                     quad_bits = {quad_bits[11:0], s};
                  end
               end
               if (line_chars_seen < LINE_CHARS + 1) line_chars_seen++;
            end
         end
         FUNC_READ_CHAR: begin
            if (row < ROWS && col < COLS) r.read_data = char_mirror[row][col];
         end
         FUNC_READ_FLAG: begin
            if (col < COLS) r.read_data = flag_mirror[col];
         end
         default: ;
      endcase
      r.graphic = (flag_mirror[0] != 8'h00);
      return r;
   endfunction

   function automatic int unsigned idle_cycles(inout bit calm);
      if ($urandom_range(0, 49) == 0) calm = !calm;
      return calm ? 0 : $urandom_range(0, 9);
   endfunction

   task automatic push_beat(input logic [1:0] func, input logic [7:0] rx,
                            input logic [4:0] row, input logic [6:0] col);
      req_beat_type b;
      b.func = func;
      b.rx   = rx;
      b.row  = row;
      b.col  = col;
      b.hold = hold_next;
      hold_next = 1'b0;
      queued_beats.push_back(b);
   endtask

   task automatic push_serial(input logic [7:0] rx);
      push_beat(FUNC_SERIAL, rx, 5'($urandom), 7'($urandom));
   endtask

   task automatic push_random_read();
      logic [1:0] func;
      int unsigned pick;
      pick = $urandom_range(0, 9);
      func = (pick < 5) ? FUNC_READ_CHAR : (pick < 9) ? FUNC_READ_FLAG : FUNC_NOP;
      push_beat(func, 8'($urandom),
                5'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 31) : $urandom_range(0, ROWS-1)),
                7'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 127) : $urandom_range(0, COLS-1)));
   endtask

   task automatic push_line(input line_kind_type kind);
      logic [7:0]  raw [PEND_LEN];
      logic [7:0]  text [$];
      logic [23:0] bits;
      logic [7:0]  c;
      logic [5:0]  unused;
      int unsigned cut;
      for (int i = 1; i < PEND_LEN; i++) raw[i] = 8'($urandom);
      if (kind == LINE_OUT_OF_SEQ) begin
         do raw[0] = 8'($urandom); while (int'(raw[0]) == gen_line);
         gen_line = 0;
      end else begin
         raw[0] = 8'(gen_line);
      end
      if (kind == LINE_GOOD) begin
         if (gen_line == ROWS) begin
            raw[1] = (gen_frames != 0 && $urandom_range(0, 1) == 0) ? 8'h00
                                                                    : 8'($urandom_range(1, 255));
            gen_frames++;
            gen_line = 0;
         end else begin
            gen_line++;
         end
      end
      for (int q = 0; q < LINE_CHARS / 4; q++) begin
         bits = {raw[3*q], raw[3*q+1], raw[3*q+2]};
         for (int k = 3; k >= 0; k--) text.push_back(sextet_char(bits[6*k +: 6]));
      end
      case (kind)
         LINE_SHORT: begin
            cut = $urandom_range(1, LINE_CHARS - 1);
            while (text.size() > cut) void'(text.pop_back());
         end
         LINE_LONG: begin
            repeat ($urandom_range(1, 12)) text.push_back(sextet_char(6'($urandom)));
         end
         LINE_BAD_CHAR: begin
            do c = 8'($urandom); while (sextet_value(c, unused) || c == CHAR_LF || c == CHAR_CR);
            text[$urandom_range(0, LINE_CHARS - 1)] = c;
         end
         LINE_NOISE: begin
            text.delete();
            repeat ($urandom_range(1, 150)) text.push_back(8'($urandom));
         end
         default: ;
      endcase
      foreach (text[i]) begin
         if ($urandom_range(0, 39) == 0) push_random_read();
         push_serial(text[i]);
      end
      case ($urandom_range(0, 2))
         0: push_serial(CHAR_CR);
         1: push_serial(CHAR_LF);
         default: begin
            push_serial(CHAR_CR);
            push_serial(CHAR_LF);
         end
      endcase
   endtask

   task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0h, got %0h", name, want, got);
         fail_count++;
      end
   endtask

   // driver
   always @(negedge clock) begin
      req_beat_type b;
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else if (!req_valid || beats_in == beats_sent) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (queued_beats.size() != 0 &&
                      !(queued_beats[0].hold && predicted_rsp.size() != 0)) begin
            b = queued_beats.pop_front();
            req_func     <= b.func;
            req_rx_byte  <= b.rx;
            req_read_row <= b.row;
            req_read_col <= b.col;
            req_valid    <= 1'b1;
            beats_sent++;
            gap_left = idle_cycles(req_calm);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result-side stall
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsps_out != rsps_seen) begin
            rsps_seen = rsps_out;
            stall_left = idle_cycles(rsp_calm);
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_beat_type want;
      cycles++;
      if (cycles > cycle_limit) begin
         $display("Test completed with failures");
         $finish;
      end else if (!reset) begin
         if (req_valid && !req_stall) begin
            predicted_rsp.push_back(receive_beat(req_func, req_rx_byte, req_read_row, req_read_col));
            beats_in++;
         end
         if (rsp_valid && !rsp_stall) begin
            rsps_out++;
            if (predicted_rsp.size() == 0) begin
               $error("result beat with no expectation pending");
               fail_count++;
            end else begin
               want = predicted_rsp.pop_front();
               check_field("read_data", want.read_data, rsp_read_data);
               check_field("line_accepted", 8'(want.accepted), 8'(rsp_line_accepted));
               check_field("line_dropped", 8'(want.dropped), 8'(rsp_line_dropped));
               check_field("frame_done", 8'(want.done), 8'(rsp_frame_done));
               check_field("graphic_mode", 8'(want.graphic), 8'(rsp_graphic_mode));
            end
         end
      end
   end

   initial begin
      line_kind_type opening [$];
      line_kind_type kind;
      int unsigned   pick, seq_no;
      line_chars_seen = 0;
      quad_bits = '0;
      line_has_bad = 1'b0;
      next_line_no = 0;
      foreach (pend_mirror[i]) pend_mirror[i] = 8'h00;
      foreach (char_mirror[r, c]) char_mirror[r][c] = CHAR_SPACE;
      foreach (flag_mirror[i]) flag_mirror[i] = 8'h00;

      push_beat(FUNC_READ_CHAR, 8'h00, 5'd0, 7'd0);
      push_beat(FUNC_READ_CHAR, 8'hFF, 5'(ROWS - 1), 7'(COLS - 1));
      push_beat(FUNC_READ_CHAR, 8'h00, 5'(ROWS), 7'd0);
      push_beat(FUNC_READ_CHAR, 8'hFF, 5'd31, 7'd127);
      push_beat(FUNC_READ_CHAR, 8'h00, 5'd0, 7'(COLS));
      push_beat(FUNC_READ_FLAG, 8'h00, 5'd0, 7'd0);
      push_beat(FUNC_READ_FLAG, 8'hFF, 5'd31, 7'(COLS - 1));
      push_beat(FUNC_READ_FLAG, 8'h00, 5'd0, 7'(COLS));
      push_beat(FUNC_READ_FLAG, 8'hFF, 5'd31, 7'd127);
      push_beat(FUNC_NOP, 8'hFF, 5'd31, 7'd127);
      push_serial(CHAR_LF);
      push_serial(CHAR_CR);
      push_serial("A");
      push_serial(CHAR_SLASH);
      push_serial(CHAR_PLUS);
      push_serial("9");
      push_serial("z");
      push_serial(CHAR_CR);
      push_serial(CHAR_LF);
      push_serial(8'h00);
      push_serial(8'hFF);
      push_serial(CHAR_LF);

      // well-formed lines dominate; broken lines and noise mixed in
      opening = '{LINE_GOOD, LINE_OUT_OF_SEQ, LINE_SHORT, LINE_LONG, LINE_BAD_CHAR, LINE_NOISE};
      gen_line = 0;
      gen_frames = 0;
      seq_no = 0;
      while (queued_beats.size() < 650) begin
         if (seq_no % 12 == 0) hold_next = 1'b1;
         if (opening.size() != 0) begin
            kind = opening.pop_front();
         end else begin
            pick = $urandom_range(0, 99);
            kind = (pick < 78) ? LINE_GOOD : (pick < 81) ? LINE_OUT_OF_SEQ :
                   (pick < 88) ? LINE_SHORT : (pick < 93) ? LINE_LONG :
                   (pick < 97) ? LINE_BAD_CHAR : LINE_NOISE;
         end
         push_line(kind);
         repeat ($urandom_range(0, 3)) push_random_read();
         seq_no++;
      end
      cycle_limit = 256 * queued_beats.size() + 50000;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      wait (queued_beats.size() == 0 && beats_in == beats_sent && predicted_rsp.size() == 0);
      repeat (COLS + 20) @(posedge clock);
      if (fail_count == 0 && predicted_rsp.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/b64lfr_pkg.sv
hdl/base64_line_frame_receiver_unit.sv
tb/base64_line_frame_receiver_unit_tb.sv
